### src/rolling_grid_map_store_defines.svh
// assertion macros for the rolling grid map store checker
// expects clk and rst_n in the scope where a macro is used
`ifndef ROLLING_GRID_MAP_STORE_DEFINES_SVH
`define ROLLING_GRID_MAP_STORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define RGMS_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property that must hold in the cycle after a condition
`define RGMS_CHECK_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

### src/rgms_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the rolling grid map store
// no dependencies
package rgms_pkg;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 64;
    localparam int PAYLOAD_BITS = 32;

    // fixed field widths of the ports
    localparam int DIM_W      = 7;
    localparam int OFS_W      = 8;
    localparam int CELL_IDX_W = 6;
    localparam int WORD_W     = 32;
    localparam int AGE_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // signed working width for offsets, coordinates and dimensions
    localparam int SW_A = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int SW_B = (DIM_W > OFS_W) ? DIM_W : OFS_W;
    localparam int SW   = ((SW_A > SW_B) ? SW_A : SW_B) + 2;

    localparam logic [ROW_W-1:0] ROW_LAST_MAX = ROW_W'(MAX_ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST_MAX = COL_W'(MAX_COLS - 1);

    localparam logic [AGE_W-1:0]      AGE_LIMIT  = AGE_W'(60000);
    localparam logic [DIM_W-1:0]      ROWS_RESET = DIM_W'(64);
    localparam logic [DIM_W-1:0]      COLS_RESET = DIM_W'(64);
    localparam logic [CFG_DATA_W-1:0] FILL_RESET = 32'h7FC0_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_FILL = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        CMD_SHIFT = 3'd0,
        CMD_AGE   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // what the cell unit puts into the addressed cell
    typedef enum logic [2:0] {
        OP_FILL,
        OP_INIT,
        OP_COPY,
        OP_AGE,
        OP_LOAD
    } cell_op_t;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [AGE_W-1:0]        seen;
        logic [AGE_W-1:0]        trusted;
    } cell_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        cell_op_t          op;
    } wr_ctl_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [OFS_W-1:0]  row_offset;
        logic [OFS_W-1:0]  col_offset;
        logic [ADDR_W-1:0] addr;
        logic              in_grid;
    } item_t;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic load_out;
    } seq_stat_t;

    function automatic logic [PAYLOAD_BITS-1:0] to_payload(input logic [WORD_W-1:0] v);
        logic [PAYLOAD_BITS+WORD_W-1:0] w;
        w = {{PAYLOAD_BITS{1'b0}}, v};
        return w[PAYLOAD_BITS-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] to_word(input logic [PAYLOAD_BITS-1:0] p);
        logic [PAYLOAD_BITS+WORD_W-1:0] w;
        w = {{WORD_W{1'b0}}, p};
        return w[WORD_W-1:0];
    endfunction

    // zero acts as one, above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > max_dim)
            r = DIM_W'(max_dim);
        else
            r = v;
        return r;
    endfunction

endpackage

### src/rgms_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for command words and result words
// depends on rgms_pkg
interface rgms_req_if;
    import rgms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [2:0]            command;
    logic signed [OFS_W-1:0] row_offset;
    logic signed [OFS_W-1:0] col_offset;
    logic [CELL_IDX_W-1:0] cell_row;
    logic [CELL_IDX_W-1:0] cell_col;
    logic [WORD_W-1:0]     cell_data;
    logic [AGE_W-1:0]      seen_age_in;
    logic [AGE_W-1:0]      trusted_age_in;

    modport source (
        output valid, command, row_offset, col_offset, cell_row, cell_col,
               cell_data, seen_age_in, trusted_age_in,
        input  ready
    );
    modport sink (
        input  valid, command, row_offset, col_offset, cell_row, cell_col,
               cell_data, seen_age_in, trusted_age_in,
        output ready
    );
endinterface

interface rgms_rsp_if;
    import rgms_pkg::*;

    logic              valid;
    logic              ready;
    logic              in_range;
    logic [WORD_W-1:0] cell_data_out;
    logic [AGE_W-1:0]  seen_age_out;
    logic [AGE_W-1:0]  trusted_age_out;

    modport source (
        output valid, in_range, cell_data_out, seen_age_out, trusted_age_out,
        input  ready
    );
    modport sink (
        input  valid, in_range, cell_data_out, seen_age_out, trusted_age_out,
        output ready
    );
endinterface

### src/rgms_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module rgms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/rgms_cell_unit.sv
`timescale 1ns / 1ps
// shared cell update unit: copy, fill, init, age increment or load of one cell
// depends on rgms_pkg
module rgms_cell_unit (
    input  rgms_pkg::wr_ctl_t                 ctl,
    input  rgms_pkg::cell_t                   rdata,
    input  logic [rgms_pkg::WORD_W-1:0]       fill,
    input  logic [rgms_pkg::WORD_W-1:0]       ld_data,
    input  logic [rgms_pkg::AGE_W-1:0]        ld_seen,
    input  logic [rgms_pkg::AGE_W-1:0]        ld_trusted,
    output rgms_pkg::cell_t                   wdata
);
    import rgms_pkg::*;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        logic [AGE_W-1:0] r;
        if (a >= AGE_LIMIT - AGE_W'(1))
            r = AGE_LIMIT;
        else
            r = a + AGE_W'(1);
        return r;
    endfunction

    function automatic logic [AGE_W-1:0] age_clip(input logic [AGE_W-1:0] a);
        return (a > AGE_LIMIT) ? AGE_LIMIT : a;
    endfunction

    always_comb
    begin
        wdata = rdata;
        unique case (ctl.op)
            OP_FILL:
            begin
                wdata.payload = to_payload(fill);
                wdata.seen    = '0;
                wdata.trusted = '0;
            end
            OP_INIT:
            begin
                wdata.payload = to_payload(FILL_RESET);
                wdata.seen    = '0;
                wdata.trusted = '0;
            end
            OP_COPY:
            begin
                wdata = rdata;
            end
            OP_AGE:
            begin
                wdata.seen    = age_inc(rdata.seen);
                wdata.trusted = age_inc(rdata.trusted);
            end
            OP_LOAD:
            begin
                wdata.payload = to_payload(ld_data);
                wdata.seen    = age_clip(ld_seen);
                wdata.trusted = age_clip(ld_trusted);
            end
            default:
            begin
                wdata = rdata;
            end
        endcase
    end

endmodule

### src/rgms_seq.sv
`timescale 1ns / 1ps
// command sequencer: decodes a word, walks the cells for shift, age tick,
// clear and the power-up fill; depends on rgms_pkg
module rgms_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  rgms_pkg::item_t               item,
    input  logic [rgms_pkg::DIM_W-1:0]    eff_rows,
    input  logic [rgms_pkg::DIM_W-1:0]    eff_cols,
    input  logic                          out_free,
    output rgms_pkg::wr_ctl_t             ctl,
    output logic [rgms_pkg::ADDR_W-1:0]   raddr,
    output rgms_pkg::seq_stat_t           stat
);
    import rgms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RD,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SC_SHIFT,
        SC_AGE,
        SC_FILL,
        SC_INIT
    } scan_t;

    state_t            state_reg, state_next;
    scan_t             mode_reg, mode_next;
    logic [ROW_W-1:0]  r_reg, r_next;
    logic [COL_W-1:0]  c_reg, c_next;
    logic [ROW_W-1:0]  row_last_reg, row_last_next;
    logic [COL_W-1:0]  col_last_reg, col_last_next;
    logic              r_desc_reg, r_desc_next;
    logic              c_desc_reg, c_desc_next;
    logic [OFS_W-1:0]  rs_reg, rs_next;
    logic [OFS_W-1:0]  cs_reg, cs_next;
    wr_ctl_t           ctl_reg, ctl_next;

    logic signed [SW-1:0] sr, sc;
    logic signed [SW-1:0] rs_w, cs_w, rs_abs, cs_abs;
    logic [SW-1:0]        rl_w, cl_w;
    logic                 src_ok;
    logic                 row_end, col_end;
    logic [ADDR_W-1:0]    dest, src;
    cell_op_t             op_sel;
    logic                 go_full, go_shift, zero_shift, large_shift;
    scan_t                go_mode;

    // source cell of the current destination during a shift
    always_comb
    begin
        sr     = $signed(SW'(r_reg)) - SW'($signed(rs_reg));
        sc     = $signed(SW'(c_reg)) - SW'($signed(cs_reg));
        src_ok = !sr[SW-1] && !sc[SW-1]
                 && ($unsigned(sr) <= SW'(row_last_reg))
                 && ($unsigned(sc) <= SW'(col_last_reg));
        dest   = {r_reg, c_reg};
        src    = {sr[ROW_W-1:0], sc[COL_W-1:0]};
        row_end = r_desc_reg ? (r_reg == '0) : (r_reg == row_last_reg);
        col_end = c_desc_reg ? (c_reg == '0) : (c_reg == col_last_reg);
    end

    always_comb
    begin
        unique case (mode_reg)
            SC_SHIFT: op_sel = src_ok ? OP_COPY : OP_FILL;
            SC_AGE:   op_sel = OP_AGE;
            SC_FILL:  op_sel = OP_FILL;
            SC_INIT:  op_sel = OP_INIT;
            default:  op_sel = OP_FILL;
        endcase
    end

    // offsets of the incoming word against the active size
    always_comb
    begin
        rs_w        = SW'($signed(item.row_offset));
        cs_w        = SW'($signed(item.col_offset));
        rs_abs      = rs_w[SW-1] ? -rs_w : rs_w;
        cs_abs      = cs_w[SW-1] ? -cs_w : cs_w;
        rl_w        = SW'(eff_rows) - SW'(1);
        cl_w        = SW'(eff_cols) - SW'(1);
        zero_shift  = (item.row_offset == '0) && (item.col_offset == '0);
        large_shift = ($unsigned(rs_abs) >= SW'(eff_rows))
                      || ($unsigned(cs_abs) >= SW'(eff_cols));
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        row_last_next = row_last_reg;
        col_last_next = col_last_reg;
        r_desc_next   = r_desc_reg;
        c_desc_next   = c_desc_reg;
        rs_next       = rs_reg;
        cs_next       = cs_reg;
        ctl_next      = ctl_reg;
        ctl_next.we   = 1'b0;
        raddr         = dest;
        go_full       = 1'b0;
        go_shift      = 1'b0;
        go_mode       = SC_FILL;

        unique case (state_reg)
            S_IDLE:
            begin
                raddr = item.addr;
                if (req_valid)
                begin
                    state_next = S_DONE;
                    unique case (item.cmd)
                        CMD_SHIFT:
                        begin
                            if (!zero_shift)
                            begin
                                if (large_shift)
                                    go_full = 1'b1;
                                else
                                    go_shift = 1'b1;
                            end
                        end
                        CMD_AGE:
                        begin
                            go_full = 1'b1;
                            go_mode = SC_AGE;
                        end
                        CMD_CLEAR:
                        begin
                            go_full = 1'b1;
                        end
                        CMD_WRITE:
                        begin
                            if (item.in_grid)
                            begin
                                ctl_next.we   = 1'b1;
                                ctl_next.addr = item.addr;
                                ctl_next.op   = OP_LOAD;
                            end
                        end
                        CMD_READ:
                        begin
                            if (item.in_grid)
                                state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (mode_reg == SC_SHIFT)
                    raddr = src;
                // write lands next cycle, once the read data is back
                ctl_next.we   = 1'b1;
                ctl_next.addr = dest;
                ctl_next.op   = op_sel;
                if (col_end)
                begin
                    c_next = c_desc_reg ? col_last_reg : '0;
                    if (row_end)
                        state_next = S_DRAIN;
                    else
                        r_next = r_desc_reg ? r_reg - ROW_W'(1) : r_reg + ROW_W'(1);
                end
                else
                begin
                    c_next = c_desc_reg ? c_reg - COL_W'(1) : c_reg + COL_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = (mode_reg == SC_INIT) ? S_IDLE : S_DONE;
            end
            S_RD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go_full)
        begin
            state_next    = S_SCAN;
            mode_next     = go_mode;
            r_next        = '0;
            c_next        = '0;
            row_last_next = ROW_LAST_MAX;
            col_last_next = COL_LAST_MAX;
            r_desc_next   = 1'b0;
            c_desc_next   = 1'b0;
        end

        // walk against the shift direction so no source is overwritten first
        if (go_shift)
        begin
            state_next    = S_SCAN;
            mode_next     = SC_SHIFT;
            rs_next       = item.row_offset;
            cs_next       = item.col_offset;
            row_last_next = rl_w[ROW_W-1:0];
            col_last_next = cl_w[COL_W-1:0];
            r_desc_next   = !rs_w[SW-1] && (rs_w != '0);
            c_desc_next   = !cs_w[SW-1] && (cs_w != '0);
            r_next        = (!rs_w[SW-1] && (rs_w != '0)) ? rl_w[ROW_W-1:0] : '0;
            c_next        = (!cs_w[SW-1] && (cs_w != '0)) ? cl_w[COL_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // power-up fill pass over the whole store
            state_reg    <= S_SCAN;
            mode_reg     <= SC_INIT;
            r_reg        <= '0;
            c_reg        <= '0;
            row_last_reg <= ROW_LAST_MAX;
            col_last_reg <= COL_LAST_MAX;
            r_desc_reg   <= 1'b0;
            c_desc_reg   <= 1'b0;
            rs_reg       <= '0;
            cs_reg       <= '0;
            ctl_reg      <= '{we: 1'b0, addr: '0, op: OP_INIT};
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            row_last_reg <= row_last_next;
            col_last_reg <= col_last_next;
            r_desc_reg   <= r_desc_next;
            c_desc_reg   <= c_desc_next;
            rs_reg       <= rs_next;
            cs_reg       <= cs_next;
            ctl_reg      <= ctl_next;
        end
    end

    assign ctl            = ctl_reg;
    assign stat.in_ready  = (state_reg == S_IDLE);
    assign stat.capture   = (state_reg == S_RD);
    assign stat.load_out  = (state_reg == S_DONE) && out_free;

endmodule

### src/rolling_grid_map_store.sv
`timescale 1ns / 1ps
// rolling grid map store top level: configuration, result register, cell memory
// depends on rgms_pkg, rgms_if, rgms_ram, rgms_cell_unit, rgms_seq
//
//  channel  dir  handshake         payload
//  req      in   valid / ready     command, offsets, cell address, cell word
//  rsp      out  valid / ready     in_range, cell word, ages
//  cfg      in   cfg_we            cfg_idx, cfg_data
//
// shift walks eff rows * eff cols cells, zero shift none, large shift as clear;
// age tick and clear walk all MAX_ROWS * MAX_COLS cells, write, read, unused none;
// one memory write port and one read port visit one cell per cycle.
// after reset a fill pass over all MAX_ROWS * MAX_COLS cells runs before the
// first word is taken. a finished result waits in the output register and
// the next word is taken at once; a word finishing while it still waits stalls.
module rolling_grid_map_store (
    input  logic                              clk,
    input  logic                              rst_n,
    rgms_req_if.sink                          req,
    rgms_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [rgms_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [rgms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rgms_pkg::*;

    logic [DIM_W-1:0]      rows_reg, cols_reg;
    logic [CFG_DATA_W-1:0] fill_reg;
    logic [DIM_W-1:0]      eff_rows, eff_cols;

    item_t                 item;
    seq_stat_t             stat;
    wr_ctl_t               ctl;
    logic [ADDR_W-1:0]     raddr;
    cell_t                 rdata, wdata;
    logic                  acc, out_free;

    logic [WORD_W-1:0]     ld_data_reg;
    logic [AGE_W-1:0]      ld_seen_reg, ld_trusted_reg;
    logic                  res_hit_reg, res_hit_next;
    cell_t                 res_cell_reg, res_cell_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;
    cell_t                 out_cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            fill_reg <= FILL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ROWS: rows_reg <= cfg_data[DIM_W-1:0];
                REG_COLS: cols_reg <= cfg_data[DIM_W-1:0];
                REG_FILL: fill_reg <= cfg_data;
                default:  fill_reg <= fill_reg;
            endcase
        end
    end

    assign eff_rows = eff_dim(rows_reg, MAX_ROWS);
    assign eff_cols = eff_dim(cols_reg, MAX_COLS);

    always_comb
    begin
        item.cmd        = cmd_t'(req.command);
        item.row_offset = req.row_offset;
        item.col_offset = req.col_offset;
        item.addr       = {ROW_W'(req.cell_row), COL_W'(req.cell_col)};
        item.in_grid    = (DIM_W'(req.cell_row) < eff_rows)
                          && (DIM_W'(req.cell_col) < eff_cols);
    end

    assign acc       = req.valid && stat.in_ready;
    assign req.ready = stat.in_ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    rgms_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .item      (item),
        .eff_rows  (eff_rows),
        .eff_cols  (eff_cols),
        .out_free  (out_free),
        .ctl       (ctl),
        .raddr     (raddr),
        .stat      (stat)
    );

    rgms_cell_unit u_cell_unit (
        .ctl        (ctl),
        .rdata      (rdata),
        .fill       (fill_reg),
        .ld_data    (ld_data_reg),
        .ld_seen    (ld_seen_reg),
        .ld_trusted (ld_trusted_reg),
        .wdata      (wdata)
    );

    rgms_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.we),
        .waddr (ctl.addr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // result of the word in flight: zero unless a read hits the active grid
    always_comb
    begin
        res_hit_next  = res_hit_reg;
        res_cell_next = res_cell_reg;
        if (acc)
        begin
            res_hit_next  = 1'b0;
            res_cell_next = '0;
        end
        else if (stat.capture)
        begin
            res_hit_next  = 1'b1;
            res_cell_next = rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        res_hit_reg  <= res_hit_next;
        res_cell_reg <= res_cell_next;
        if (acc)
        begin
            ld_data_reg    <= req.cell_data;
            ld_seen_reg    <= req.seen_age_in;
            ld_trusted_reg <= req.trusted_age_in;
        end
        if (stat.load_out)
        begin
            out_hit_reg  <= res_hit_reg;
            out_cell_reg <= res_cell_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stat.load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.in_range        = out_hit_reg;
    assign rsp.cell_data_out   = to_word(out_cell_reg.payload);
    assign rsp.seen_age_out    = out_cell_reg.seen;
    assign rsp.trusted_age_out = out_cell_reg.trusted;

endmodule

### src/rgms_checker.sv
`timescale 1ns / 1ps
// port-level checker for the rolling grid map store and its bind
// depends on rgms_pkg and rolling_grid_map_store_defines.svh
`include "rolling_grid_map_store_defines.svh"

module rgms_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          in_range,
    input logic [rgms_pkg::WORD_W-1:0]   cell_data_out,
    input logic [rgms_pkg::AGE_W-1:0]    seen_age_out,
    input logic [rgms_pkg::AGE_W-1:0]    trusted_age_out
);
    import rgms_pkg::*;

    // words taken whose result has not been taken yet
    logic [1:0] owed_reg, owed_next;
    logic       in_acc, out_acc;

    assign in_acc  = req_valid && req_ready;
    assign out_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        owed_next = owed_reg;
        if (in_acc && !out_acc)
            owed_next = owed_reg + 2'd1;
        else if (out_acc && !in_acc)
            owed_next = owed_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            owed_reg <= '0;
        else
            owed_reg <= owed_next;
    end

    `RGMS_CHECK(a_no_orphan, !rsp_valid || (owed_reg != 2'd0), "result word without a command word")
    `RGMS_CHECK(a_owed_bound, owed_reg != 2'd3, "more than two words outstanding")
    `RGMS_CHECK(a_miss_zero, !rsp_valid || in_range || ((cell_data_out == '0) && (seen_age_out == '0) && (trusted_age_out == '0)), "out of range result not zero")
    `RGMS_CHECK(a_age_limit, !rsp_valid || ((seen_age_out <= AGE_LIMIT) && (trusted_age_out <= AGE_LIMIT)), "age above limit")
    `RGMS_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")

endmodule

bind rolling_grid_map_store rgms_checker u_rgms_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .in_range        (rsp.in_range),
    .cell_data_out   (rsp.cell_data_out),
    .seen_age_out    (rsp.seen_age_out),
    .trusted_age_out (rsp.trusted_age_out)
);

### verif/rolling_grid_map_store_checker.sv
`timescale 1ns / 1ps
// checker for the rolling grid map store: mirrors the cell map and config registers,
// predicts the result word of every accepted command word and compares it
// depends on rgms_pkg and rgms_if
module rolling_grid_map_store_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    rgms_req_if                             req,
    rgms_rsp_if                             rsp,
    input  logic                            cfg_we,
    input  logic [rgms_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rgms_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fails,
    output int                              pending
);
    import rgms_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] word;
        logic [AGE_W-1:0]  seen;
        logic [AGE_W-1:0]  trusted;
    } reading_t;

    logic [PAYLOAD_BITS-1:0] map_payload [CELLS];
    logic [AGE_W-1:0]        map_seen    [CELLS];
    logic [AGE_W-1:0]        map_trusted [CELLS];
    logic [PAYLOAD_BITS-1:0] next_payload [CELLS];
    logic [AGE_W-1:0]        next_seen    [CELLS];
    logic [AGE_W-1:0]        next_trusted [CELLS];

    logic [DIM_W-1:0]      rows_cfg;
    logic [DIM_W-1:0]      cols_cfg;
    logic [CFG_DATA_W-1:0] fill_cfg;

    reading_t due_readings [$];
    reading_t want;
    reading_t got;
    int       bad = 0;

    function automatic int span(input logic [DIM_W-1:0] v, input int lim);
        if (v == '0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic logic [AGE_W-1:0] age_clip(input logic [AGE_W-1:0] a);
        return (a > AGE_LIMIT) ? AGE_LIMIT : a;
    endfunction

    function automatic void wipe_map();
        for (int i = 0; i < CELLS; i++)
        begin
            map_payload[i] = PAYLOAD_BITS'(fill_cfg);
            map_seen[i]    = '0;
            map_trusted[i] = '0;
        end
    endfunction

    function automatic void age_map();
        for (int i = 0; i < CELLS; i++)
        begin
            map_seen[i]    = (map_seen[i] >= AGE_LIMIT) ? AGE_LIMIT : map_seen[i] + 1'b1;
            map_trusted[i] = (map_trusted[i] >= AGE_LIMIT) ? AGE_LIMIT : map_trusted[i] + 1'b1;
        end
    endfunction

    // cell (r,c) takes the old content of (r-dr, c-dc) inside the active window
    function automatic void scroll_map(input int dr, input int dc);
        int nr;
        int nc;
        int sr;
        int sc;
        int d;
        int s;
        nr = span(rows_cfg, MAX_ROWS);
        nc = span(cols_cfg, MAX_COLS);
        if (dr == 0 && dc == 0)
            return;
        if ((dr < 0 ? -dr : dr) >= nr || (dc < 0 ? -dc : dc) >= nc)
        begin
            wipe_map();
            return;
        end
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                d  = r * MAX_COLS + c;
                sr = r - dr;
                sc = c - dc;
                if (sr < 0 || sr >= nr || sc < 0 || sc >= nc)
                begin
                    next_payload[d] = PAYLOAD_BITS'(fill_cfg);
                    next_seen[d]    = '0;
                    next_trusted[d] = '0;
                end
                else
                begin
                    s = sr * MAX_COLS + sc;
                    next_payload[d] = map_payload[s];
                    next_seen[d]    = map_seen[s];
                    next_trusted[d] = map_trusted[s];
                end
            end
        end
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                d = r * MAX_COLS + c;
                map_payload[d] = next_payload[d];
                map_seen[d]    = next_seen[d];
                map_trusted[d] = next_trusted[d];
            end
        end
    endfunction

    function automatic reading_t predict_reading(
        input logic [2:0]            op,
        input int                    dr,
        input int                    dc,
        input logic [CELL_IDX_W-1:0] row,
        input logic [CELL_IDX_W-1:0] col,
        input logic [WORD_W-1:0]     data,
        input logic [AGE_W-1:0]      seen_in,
        input logic [AGE_W-1:0]      trusted_in
    );
        reading_t res;
        logic     in_grid;
        int       idx;
        res     = '0;
        in_grid = int'(row) < span(rows_cfg, MAX_ROWS) && int'(col) < span(cols_cfg, MAX_COLS);
        idx     = int'(row) * MAX_COLS + int'(col);
        case (op)
            CMD_SHIFT: scroll_map(dr, dc);
            CMD_AGE:   age_map();
            CMD_CLEAR: wipe_map();
            CMD_WRITE:
                if (in_grid && idx < CELLS)
                begin
                    map_payload[idx] = PAYLOAD_BITS'(data);
                    map_seen[idx]    = age_clip(seen_in);
                    map_trusted[idx] = age_clip(trusted_in);
                end
            CMD_READ:
                if (in_grid && idx < CELLS)
                begin
                    res.hit     = 1'b1;
                    res.word    = WORD_W'(map_payload[idx]);
                    res.seen    = map_seen[idx];
                    res.trusted = map_trusted[idx];
                end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg = ROWS_RESET;
            cols_cfg = COLS_RESET;
            fill_cfg = FILL_RESET;
            wipe_map();
            due_readings.delete();
            pending <= 0;
            fails   <= bad;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_ROWS: rows_cfg = cfg_data[DIM_W-1:0];
                    REG_COLS: cols_cfg = cfg_data[DIM_W-1:0];
                    REG_FILL: fill_cfg = cfg_data;
                    default: ;
                endcase
            end
            // results leave before the word taken at this edge can have one
            if (rsp.valid && rsp.ready)
            begin
                got.hit     = rsp.in_range;
                got.word    = rsp.cell_data_out;
                got.seen    = rsp.seen_age_out;
                got.trusted = rsp.trusted_age_out;
                if (due_readings.size() == 0)
                begin
                    if (bad < 10)
                        $display("%0t: result word with none expected: in_range %0b word %h",
                                 $time, got.hit, got.word);
                    bad++;
                end
                else
                begin
                    want = due_readings.pop_front();
                    if (got !== want)
                    begin
                        if (bad < 10)
                        begin
                            $display("%0t: mismatch, expected in_range %0b word %h seen %0d trusted %0d",
                                     $time, want.hit, want.word, want.seen, want.trusted);
                            $display("%0t:           got      in_range %0b word %h seen %0d trusted %0d",
                                     $time, got.hit, got.word, got.seen, got.trusted);
                        end
                        bad++;
                    end
                end
            end
            if (req.valid && req.ready)
                due_readings.push_back(predict_reading(req.command, $signed(req.row_offset),
                                                       $signed(req.col_offset), req.cell_row,
                                                       req.cell_col, req.cell_data,
                                                       req.seen_age_in, req.trusted_age_in));
            pending <= due_readings.size();
            fails   <= bad;
        end
    end

endmodule

### verif/rolling_grid_map_store_test.sv
`timescale 1ns / 1ps
// top of the rolling grid map store testbench: clock, reset, command and config stimulus,
// result-side stalls and the verdict; checking lives in rolling_grid_map_store_checker
// depends on rgms_pkg, rgms_if, rolling_grid_map_store and the checker
module rolling_grid_map_store_test;
    import rgms_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int RAND_PHASES     = 5;
    localparam int WORDS_PER_PHASE = 23;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fails;
    int                    pending;
    bit                    calm;
    int                    rows_eff;
    int                    cols_eff;
    logic [11:0]           recent [$];

    rgms_req_if req_ch ();
    rgms_rsp_if rsp_ch ();

    rolling_grid_map_store u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    rolling_grid_map_store_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .fails    (fails),
        .pending  (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall before each word, none while calm
    initial
    begin
        int hold;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    task automatic push_command(
        input logic [2:0]  op,
        input logic [7:0]  dr,
        input logic [7:0]  dc,
        input logic [5:0]  r,
        input logic [5:0]  c,
        input logic [31:0] d,
        input logic [15:0] sa,
        input logic [15:0] ta
    );
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= op;
        req_ch.row_offset     <= dr;
        req_ch.col_offset     <= dc;
        req_ch.cell_row       <= r;
        req_ch.cell_col       <= c;
        req_ch.cell_data      <= d;
        req_ch.seen_age_in    <= sa;
        req_ch.trusted_age_in <= ta;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic cell_write(input logic [5:0] r, input logic [5:0] c, input logic [31:0] d,
                              input logic [15:0] sa, input logic [15:0] ta);
        push_command(CMD_WRITE, 8'($urandom), 8'($urandom), r, c, d, sa, ta);
    endtask

    task automatic cell_read(input logic [5:0] r, input logic [5:0] c);
        push_command(CMD_READ, 8'($urandom), 8'($urandom), r, c, $urandom,
                     16'($urandom), 16'($urandom));
    endtask

    task automatic scroll(input logic [7:0] dr, input logic [7:0] dc);
        push_command(CMD_SHIFT, dr, dc, 6'($urandom), 6'($urandom), $urandom,
                     16'($urandom), 16'($urandom));
    endtask

    task automatic plain_op(input logic [2:0] op);
        push_command(op, 8'($urandom), 8'($urandom), 6'($urandom), 6'($urandom), $urandom,
                     16'($urandom), 16'($urandom));
    endtask

    // hold the command side until every result word is back
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [6:0] rows, input logic [6:0] cols,
                              input logic [31:0] fill);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_ROWS;
        cfg_data <= {25'($urandom), rows};
        @(posedge clk);
        cfg_idx  <= REG_COLS;
        cfg_data <= {25'($urandom), cols};
        @(posedge clk);
        cfg_idx  <= REG_FILL;
        cfg_data <= fill;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rows_eff = (rows == 0) ? 1 : ((int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows));
        cols_eff = (cols == 0) ? 1 : ((int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols));
    endtask

    function automatic logic [6:0] pick_span();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 5)
            return 7'($urandom_range(1, 4));
        if (sel < 15)
            return 7'($urandom_range(5, 16));
        if (sel < 18)
            return 7'($urandom_range(17, 64));
        return $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
    endfunction

    // ages near the ceiling so that ticks saturate, some beyond it
    function automatic logic [15:0] age_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return 16'($urandom);
        if (sel < 5)
            return 16'($urandom_range(59995, 60000));
        return 16'($urandom_range(0, 100));
    endfunction

    function automatic int small_offset(input int dim);
        int lim;
        int v;
        lim = (dim - 1 < 3) ? dim - 1 : 3;
        v   = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    initial
    begin
        logic [5:0] r;
        logic [5:0] c;
        int         sel;
        int         done;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_READ;
        req_ch.row_offset     = '0;
        req_ch.col_offset     = '0;
        req_ch.cell_row       = '0;
        req_ch.cell_col       = '0;
        req_ch.cell_data      = '0;
        req_ch.seen_age_in    = '0;
        req_ch.trusted_age_in = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_ROWS;
        cfg_data = '0;
        calm     = 1'b0;
        rows_eff = MAX_ROWS;
        cols_eff = MAX_COLS;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: full grid, quiet nan fill
        cell_read(6'd0, 6'd0);
        cell_write(6'd0, 6'd0, 32'hFFFF_FFFF, 16'd60000, 16'hFFFF);
        cell_write(6'd63, 6'd63, 32'h0, 16'd0, 16'd60001);
        cell_write(6'd63, 6'd0, 32'hA5A5_5A5A, 16'd59999, 16'd1);
        plain_op(CMD_AGE);
        cell_read(6'd0, 6'd0);
        cell_read(6'd63, 6'd0);
        scroll(8'd0, 8'd0);
        scroll(8'(-63), 8'd1);
        cell_read(6'd0, 6'd1);
        cell_read(6'd63, 6'd63);
        scroll(8'd127, 8'(-128));
        cell_read(6'd0, 6'd1);
        plain_op(CMD_SPARE_FIRST);
        plain_op(CMD_SPARE_LAST);
        cell_write(6'd10, 6'd10, 32'h1234_5678, 16'd7, 16'd9);
        plain_op(CMD_CLEAR);
        cell_read(6'd10, 6'd10);
        settle();

        // zero rows act as one, oversize columns as the maximum
        set_config(7'd0, 7'd127, 32'h0);
        cell_write(6'd0, 6'd5, 32'hDEAD_BEEF, 16'd3, 16'd4);
        cell_write(6'd1, 6'd5, 32'h0BAD_F00D, 16'd5, 16'd6);
        cell_read(6'd1, 6'd5);
        scroll(8'd0, 8'd1);
        cell_read(6'd0, 6'd6);
        cell_read(6'd0, 6'd0);
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                set_config(7'd64, 7'd64, 32'hFFFF_FFFF);
            else if (p == 1)
                set_config(7'd127, 7'd1, 32'h0);
            else
                set_config(pick_span(), pick_span(), $urandom);
            calm = (p == 2);
            recent.delete();
            done = 0;
            while (done < WORDS_PER_PHASE)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 34)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        r = 6'($urandom);
                        c = 6'($urandom);
                    end
                    else
                    begin
                        r = 6'($urandom_range(0, rows_eff - 1));
                        c = 6'($urandom_range(0, cols_eff - 1));
                    end
                    cell_write(r, c, $urandom, age_value(), age_value());
                    recent.push_back({r, c});
                    if (recent.size() > 8)
                        void'(recent.pop_front());
                    done++;
                end
                else if (sel < 70)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 5 && recent.size() > 0)
                        {r, c} = recent[$urandom_range(0, recent.size() - 1)];
                    else if (sel < 9)
                    begin
                        r = 6'($urandom_range(0, rows_eff - 1));
                        c = 6'($urandom_range(0, cols_eff - 1));
                    end
                    else
                    begin
                        r = 6'($urandom);
                        c = 6'($urandom);
                    end
                    cell_read(r, c);
                    done++;
                end
                else if (sel < 86)
                begin
                    // mostly real scrolls, now and then a wild one that can wipe the map
                    if ($urandom_range(0, 3) == 0)
                        scroll(8'($urandom), 8'($urandom));
                    else
                        scroll(8'(small_offset(rows_eff)), 8'(small_offset(cols_eff)));
                    done++;
                end
                else if (sel < 92)
                begin
                    plain_op(CMD_AGE);
                    done++;
                end
                else if (sel < 96)
                begin
                    plain_op(CMD_CLEAR);
                    done++;
                end
                else
                    plain_op(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
            end
            settle();
        end

        calm = 1'b0;
        repeat (20) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### rolling_grid_map_store.f
+incdir+src
src/rgms_pkg.sv
src/rgms_if.sv
src/rgms_ram.sv
src/rgms_cell_unit.sv
src/rgms_seq.sv
src/rolling_grid_map_store.sv
src/rgms_checker.sv
verif/rolling_grid_map_store_checker.sv
verif/rolling_grid_map_store_test.sv
